// ===== rtl/core/u8u16_pkg.sv =====
// Package for the UTF-8 to UTF-16 transcoder: result kinds, result and push types,
// byte and code point constants. No dependencies.
package u8u16_pkg;

	localparam int COUNT_WIDTH_DEFAULT = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] LEAD_MIN = 8'hC0;
	localparam logic [7:0] LEAD_MAX = 8'hFD;
	localparam logic [1:0] CONT_TAG = 2'b10;
	localparam logic [30:0] CODE_MAX = 31'h10FFFF;
	localparam logic [15:0] SURR_HIGH_BASE = 16'hD800;
	localparam logic [15:0] SURR_LOW_BASE = 16'hDC00;
	localparam logic [15:0] SURR_OFFSET = 16'h0040;

	typedef enum logic [1:0] {
		KIND_UNIT = 2'd0,
		KIND_END = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef struct packed {
		logic [15:0] unit_word;
		kind_t kind;
		logic [15:0] unit_count;
		logic last;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t first;
		result_t second;
	} push_t;

endpackage

// ===== rtl/core/u8u16_in_if.sv =====
// Byte input channel of the transcoder: valid, ready and one UTF-8 byte.
// No dependencies.
interface u8u16_in_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

// ===== rtl/core/u8u16_out_if.sv =====
// Result output channel of the transcoder: valid, ready and one result item.
// Depends on u8u16_pkg for the result kind type.
interface u8u16_out_if import u8u16_pkg::*; ();
	logic valid;
	logic ready;
	logic [15:0] unit_word;
	kind_t kind;
	logic [15:0] unit_count;
	logic last;

	modport source (output valid, output unit_word, output kind, output unit_count,
		output last, input ready);
	modport sink (input valid, input unit_word, input kind, input unit_count,
		input last, output ready);
endinterface

// ===== rtl/core/utf8_to_utf16_transcoder.sv =====
// UTF-8 to UTF-16 transcoder top level: input byte register, decoder, result queue.
// A byte waits in the input register until the queue has room; a surrogate pair's
// second result is offered one transaction after its first. Throughput: one byte per
// cycle while the queue has room; the single output port sets the limit when a byte
// yields two results. Reset empties the input register and queue, clears decoder state.
module utf8_to_utf16_transcoder import u8u16_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	u8u16_in_if.sink byte_stream,
	u8u16_out_if.source unit_stream
);

	logic valid_s1;
	logic [7:0] data_s1;
	logic fire;
	logic room;
	push_t push;
	result_t out_data;
	logic out_valid;

	assign fire = valid_s1 && room;
	assign byte_stream.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_stream.ready) begin
			valid_s1 <= byte_stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_stream.ready && byte_stream.valid) begin
			data_s1 <= byte_stream.data_byte;
		end
	end

	u8u16_decode #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_decode (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.data_byte(data_s1),
		.push(push)
	);

	u8u16_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.room(room),
		.out_valid(out_valid),
		.out_ready(unit_stream.ready),
		.out_data(out_data)
	);

	assign unit_stream.valid = out_valid;
	assign unit_stream.unit_word = out_data.unit_word;
	assign unit_stream.kind = out_data.kind;
	assign unit_stream.unit_count = out_data.unit_count;
	assign unit_stream.last = out_data.last;

endmodule

// ===== rtl/core/u8u16_decode.sv =====
// Decoder stage: holds the code point, pending byte count, discard flag and unit
// count, and turns one registered byte into zero, one or two results. Uses u8u16_pkg.
module u8u16_decode import u8u16_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic fire,
	input logic [7:0] data_byte,
	output push_t push
);

	logic [30:0] acc_q, acc_d;
	logic [2:0] rem_q, rem_d;
	logic disc_q, disc_d;
	logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
	logic [COUNT_WIDTH:0] cnt_sum;
	logic [1:0] add_n;
	logic [30:0] acc_shift;
	logic [30:0] emit_cp;
	logic emit_en;
	logic err_en;
	push_t push_c;

	assign acc_shift = {acc_q[24:0], data_byte[5:0]};
	assign cnt_sum = {1'b0, cnt_q} + (COUNT_WIDTH + 1)'(add_n);

	always_comb begin
		acc_d = acc_q;
		rem_d = rem_q;
		disc_d = disc_q;
		add_n = 2'd0;
		emit_en = 1'b0;
		emit_cp = '0;
		err_en = 1'b0;
		push_c = '0;
		push_c.first.kind = KIND_UNIT;
		push_c.second.kind = KIND_UNIT;
		if (data_byte == 8'h00) begin
			if (!disc_q && rem_q != 3'd0) begin
				push_c.count = 2'd2;
				push_c.first.kind = KIND_ERROR;
				push_c.second.kind = KIND_END;
				push_c.second.unit_count = 16'(cnt_q);
				push_c.second.last = 1'b1;
			end else begin
				push_c.count = 2'd1;
				push_c.first.kind = KIND_END;
				push_c.first.unit_count = 16'(cnt_q);
				push_c.first.last = 1'b1;
			end
			acc_d = '0;
			rem_d = 3'd0;
			disc_d = 1'b0;
		end else if (!disc_q) begin
			if (rem_q != 3'd0) begin
				if (data_byte[7:6] != CONT_TAG) begin
					err_en = 1'b1;
				end else begin
					acc_d = acc_shift;
					rem_d = rem_q - 3'd1;
					if (rem_q == 3'd1) begin
						emit_en = 1'b1;
						emit_cp = acc_shift;
					end
				end
			end else if (!data_byte[7]) begin
				emit_en = 1'b1;
				emit_cp = {23'd0, data_byte};
			end else if (data_byte < LEAD_MIN || data_byte > LEAD_MAX) begin
				err_en = 1'b1;
			end else begin
				priority if (!data_byte[5]) begin
					acc_d = {26'd0, data_byte[4:0]};
					rem_d = 3'd1;
				end else if (!data_byte[4]) begin
					acc_d = {27'd0, data_byte[3:0]};
					rem_d = 3'd2;
				end else if (!data_byte[3]) begin
					acc_d = {28'd0, data_byte[2:0]};
					rem_d = 3'd3;
				end else if (!data_byte[2]) begin
					acc_d = {29'd0, data_byte[1:0]};
					rem_d = 3'd4;
				end else begin
					acc_d = {30'd0, data_byte[0]};
					rem_d = 3'd5;
				end
			end
			if (emit_en) begin
				acc_d = '0;
				if (emit_cp[30:16] == 15'd0) begin
					push_c.count = 2'd1;
					push_c.first.unit_word = emit_cp[15:0];
					push_c.first.last = 1'b1;
					add_n = 2'd1;
				end else if (emit_cp <= CODE_MAX) begin
					push_c.count = 2'd2;
					push_c.first.unit_word = SURR_HIGH_BASE + {5'd0, emit_cp[20:10]}
						- SURR_OFFSET;
					push_c.second.unit_word = SURR_LOW_BASE | {6'd0, emit_cp[9:0]};
					push_c.second.last = 1'b1;
					add_n = 2'd2;
				end else begin
					err_en = 1'b1;
				end
			end
			if (err_en) begin
				push_c.count = 2'd1;
				push_c.first = '0;
				push_c.first.kind = KIND_ERROR;
				push_c.first.last = 1'b1;
				disc_d = 1'b1;
				rem_d = 3'd0;
				acc_d = '0;
			end
		end
	end

	always_comb begin
		if (data_byte == 8'h00) begin
			cnt_d = '0;
		end else if (cnt_sum[COUNT_WIDTH]) begin
			cnt_d = {COUNT_WIDTH{1'b1}};
		end else begin
			cnt_d = cnt_sum[COUNT_WIDTH-1:0];
		end
	end

	always_comb begin
		push = push_c;
		if (!fire) begin
			push.count = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			rem_q <= 3'd0;
			disc_q <= 1'b0;
			cnt_q <= '0;
		end else if (fire) begin
			acc_q <= acc_d;
			rem_q <= rem_d;
			disc_q <= disc_d;
			cnt_q <= cnt_d;
		end
	end

	a_disc_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		disc_q |-> rem_q == 3'd0)
		else $error("discard flag set while continuation bytes are pending");

	a_nul_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && data_byte == 8'h00 |=> rem_q == 3'd0 && !disc_q && cnt_q == '0)
		else $error("state not cleared after end of string");

	a_push_only_on_fire: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |-> push.count == 2'd0)
		else $error("results pushed without a decoded byte");

endmodule

// ===== rtl/core/u8u16_outq.sv =====
// Result queue: takes up to two results per cycle from the decoder and hands
// them out one per transaction. Uses u8u16_pkg.
module u8u16_outq import u8u16_pkg::*; (
	input logic clk,
	input logic arst_n,
	input push_t push,
	output logic room,
	output logic out_valid,
	input logic out_ready,
	output result_t out_data
);

	result_t entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic pop;

	assign out_valid = count_q != '0;
	assign out_data = entry_q[rd_ptr_q];
	assign pop = out_valid && out_ready;
	assign room = count_q <= QCNT_W'(QUEUE_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			entry_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			entry_q[wr_ptr_q + QPTR_W'(1)] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push.count) - QCNT_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |-> count_q <= QCNT_W'(QUEUE_DEPTH - 2))
		else $error("result queue push without room");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("result queue count out of range");

endmodule

// ===== dv/tb_utf8_to_utf16_transcoder.sv =====
// Self-checking testbench for utf8_to_utf16_transcoder: a directed byte table, an
// idle-free ASCII string and random UTF-8 strings, checked against a byte decoder.
// Depends on u8u16_pkg, u8u16_in_if, u8u16_out_if and the transcoder RTL.
module tb_utf8_to_utf16_transcoder;
	import u8u16_pkg::*;

	localparam int COUNT_W = COUNT_WIDTH_DEFAULT;
	localparam longint COUNT_MAX = (longint'(1) << COUNT_W) - 1;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_BYTES = 750;
	localparam int CALM_BYTES = 120;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [1:0] n_typed;
		result_t typed_a;
		result_t typed_b;
	} directed_step_t;

	localparam result_t NONE = '0;
	localparam result_t END_ZERO = '{16'h0000, KIND_END, 16'd0, 1'b1};
	localparam result_t ERR_LAST = '{16'h0000, KIND_ERROR, 16'd0, 1'b1};
	localparam result_t ERR_MID = '{16'h0000, KIND_ERROR, 16'd0, 1'b0};

	localparam directed_step_t DIRECTED_STEPS [26] = '{
		'{8'h00, 2'd1, END_ZERO, NONE},
		'{8'h41, 2'd1, '{16'h0041, KIND_UNIT, 16'd0, 1'b1}, NONE},
		'{8'h7F, 2'd1, '{16'h007F, KIND_UNIT, 16'd0, 1'b1}, NONE},
		'{8'hC2, 2'd0, NONE, NONE},
		'{8'h80, 2'd0, NONE, NONE},
		'{8'hEF, 2'd0, NONE, NONE},
		'{8'hBF, 2'd0, NONE, NONE},
		'{8'hBF, 2'd0, NONE, NONE},
		'{8'hF4, 2'd0, NONE, NONE},
		'{8'h8F, 2'd0, NONE, NONE},
		'{8'hBF, 2'd0, NONE, NONE},
		'{8'hBF, 2'd0, NONE, NONE},
		'{8'hF4, 2'd0, NONE, NONE},
		'{8'h90, 2'd0, NONE, NONE},
		'{8'h80, 2'd0, NONE, NONE},
		'{8'h80, 2'd1, ERR_LAST, NONE},
		'{8'h41, 2'd0, NONE, NONE},
		'{8'h00, 2'd0, NONE, NONE},
		'{8'hFF, 2'd1, ERR_LAST, NONE},
		'{8'h00, 2'd1, END_ZERO, NONE},
		'{8'hC3, 2'd0, NONE, NONE},
		'{8'h41, 2'd1, ERR_LAST, NONE},
		'{8'h00, 2'd1, END_ZERO, NONE},
		'{8'hE2, 2'd0, NONE, NONE},
		'{8'h82, 2'd0, NONE, NONE},
		'{8'h00, 2'd2, ERR_MID, END_ZERO}
	};

	logic clk;
	logic arst_n;

	u8u16_in_if byte_ch();
	u8u16_out_if unit_ch();

	utf8_to_utf16_transcoder #(
		.COUNT_WIDTH(COUNT_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_stream(byte_ch),
		.unit_stream(unit_ch)
	);

	logic [30:0] code_acc = '0;
	logic [2:0] conts_left = '0;
	bit dropping = 1'b0;
	longint units_in_string = 0;

	result_t expected_units [$];
	result_t oldest;
	int mismatches = 0;
	int quiet_cycles = 0;
	bit in_calm = 1'b0;
	bit out_calm = 1'b0;
	int hold_asks = 0;
	int hold_seen = 0;
	int hold_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic decode_byte(input logic [7:0] b, output result_t first,
		output result_t second, output int n);
		result_t res [2];
		logic bad;
		logic done;
		logic [30:0] cp;
		res[0] = '0;
		res[1] = '0;
		n = 0;
		bad = 1'b0;
		done = 1'b0;
		cp = '0;
		if (b == 8'h00) begin
			if (!dropping && conts_left != 0) begin
				res[0].kind = KIND_ERROR;
				n = 1;
			end
			res[n].kind = KIND_END;
			res[n].unit_count = units_in_string[15:0];
			n++;
			code_acc = '0;
			conts_left = '0;
			dropping = 1'b0;
			units_in_string = 0;
		end else if (!dropping) begin
			if (conts_left != 0) begin
				if (b[7:6] != CONT_TAG) begin
					bad = 1'b1;
				end else begin
					code_acc = {code_acc[24:0], b[5:0]};
					conts_left--;
					done = (conts_left == 0);
					cp = code_acc;
				end
			end else if (b < 8'h80) begin
				done = 1'b1;
				cp = {23'd0, b};
			end else if (b < LEAD_MIN || b > LEAD_MAX) begin
				bad = 1'b1;
			end else if (b < 8'hE0) begin
				code_acc = {26'd0, b[4:0]};
				conts_left = 3'd1;
			end else if (b < 8'hF0) begin
				code_acc = {27'd0, b[3:0]};
				conts_left = 3'd2;
			end else if (b < 8'hF8) begin
				code_acc = {28'd0, b[2:0]};
				conts_left = 3'd3;
			end else if (b < 8'hFC) begin
				code_acc = {29'd0, b[1:0]};
				conts_left = 3'd4;
			end else begin
				code_acc = {30'd0, b[0]};
				conts_left = 3'd5;
			end
			if (done && cp > CODE_MAX) bad = 1'b1;
			if (bad) begin
				dropping = 1'b1;
				conts_left = '0;
				code_acc = '0;
				res[0].kind = KIND_ERROR;
				n = 1;
			end else if (done) begin
				code_acc = '0;
				if (cp <= 31'h00FFFF) begin
					res[0].unit_word = cp[15:0];
					n = 1;
				end else begin
					res[0].unit_word = SURR_HIGH_BASE + 16'(cp >> 10) - SURR_OFFSET;
					res[1].unit_word = SURR_LOW_BASE + {6'd0, cp[9:0]};
					n = 2;
				end
				units_in_string = (units_in_string + n > COUNT_MAX) ?
					COUNT_MAX : units_in_string + n;
			end
		end
		if (n > 0) res[n - 1].last = 1'b1;
		first = res[0];
		second = res[1];
	endtask

	task automatic send_byte(input logic [7:0] b, input int n_typed, input result_t typed_a,
		input result_t typed_b);
		result_t r0;
		result_t r1;
		int n;
		while (!in_calm && $urandom_range(99) < 22) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= b;
		do @(posedge clk); while (!byte_ch.ready);
		decode_byte(b, r0, r1, n);
		if (n_typed > 0) begin
			n = n_typed;
			r0 = typed_a;
			r1 = typed_b;
		end
		if (n > 0) expected_units.push_back(r0);
		if (n > 1) expected_units.push_back(r1);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			unit_ch.ready <= 1'b0;
		end else if (hold_seen != hold_asks) begin
			hold_seen = hold_asks;
			hold_left = HOLD_CYCLES;
			unit_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			unit_ch.ready <= 1'b0;
		end else begin
			unit_ch.ready <= out_calm || ($urandom_range(99) >= 22);
		end
	end

	always @(posedge clk) begin
		if (arst_n && unit_ch.valid && unit_ch.ready) begin
			if (expected_units.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected transaction: unit %h kind %0d count %0d last %0b",
						unit_ch.unit_word, unit_ch.kind, unit_ch.unit_count, unit_ch.last);
			end else begin
				oldest = expected_units.pop_front();
				if (unit_ch.unit_word !== oldest.unit_word || unit_ch.kind !== oldest.kind ||
					unit_ch.unit_count !== oldest.unit_count || unit_ch.last !== oldest.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected unit %h kind %0d count %0d last %0b,",
							" got unit %h kind %0d count %0d last %0b",
							oldest.unit_word, oldest.kind, oldest.unit_count, oldest.last,
							unit_ch.unit_word, unit_ch.kind, unit_ch.unit_count, unit_ch.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_ch.valid && byte_ch.ready) || (unit_ch.valid && unit_ch.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("DONE: errors detected");
					$finish;
				end
			end
		end
	end

	initial begin
		logic [7:0] random_bytes [$];
		logic [7:0] prefix;
		logic [7:0] mask;
		logic [31:0] top;
		logic [30:0] cp;
		int i;
		int pick;
		int len;
		int keep;
		int nchars;
		clk = 1'b0;
		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = 8'h00;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < 26; i++)
			send_byte(DIRECTED_STEPS[i].data_byte, DIRECTED_STEPS[i].n_typed,
				DIRECTED_STEPS[i].typed_a, DIRECTED_STEPS[i].typed_b);

		// An ASCII string is sent and taken without any idle cycle on either side.
		in_calm = 1'b1;
		out_calm = 1'b1;
		for (i = 0; i < CALM_BYTES; i++)
			send_byte(8'($urandom_range(127, 1)), 0, NONE, NONE);
		send_byte(8'h00, 0, NONE, NONE);
		in_calm = 1'b0;
		out_calm = 1'b0;

		while (random_bytes.size() < RANDOM_BYTES) begin
			nchars = $urandom_range(10);
			repeat (nchars) begin
				pick = $urandom_range(99);
				if (pick < 35) len = 1;
				else if (pick < 50) len = 2;
				else if (pick < 65) len = 3;
				else if (pick < 80) len = 4;
				else if (pick < 86) len = $urandom_range(6, 5);
				else if (pick < 94) len = $urandom_range(6, 2);
				else len = 0;
				if (len == 0) begin
					random_bytes.push_back(8'($urandom_range(255, 1)));
				end else if (len == 1) begin
					random_bytes.push_back(8'($urandom_range(127, 1)));
				end else begin
					top = (32'h1 << (5 * len + 1)) - 1;
					if (len >= 4 && $urandom_range(9) < 7) top = 32'h0010FFFF;
					cp = 31'($urandom_range(top));
					case (len)
						2: begin prefix = 8'hC0; mask = 8'h1F; end
						3: begin prefix = 8'hE0; mask = 8'h0F; end
						4: begin prefix = 8'hF0; mask = 8'h07; end
						5: begin prefix = 8'hF8; mask = 8'h03; end
						default: begin prefix = 8'hFC; mask = 8'h01; end
					endcase
					random_bytes.push_back(prefix | (8'(cp >> (6 * (len - 1))) & mask));
					keep = (pick >= 86) ? $urandom_range(len - 2) : len - 1;
					for (i = len - 2; i > len - 2 - keep; i--)
						random_bytes.push_back(8'h80 | (8'(cp >> (6 * i)) & 8'h3F));
				end
			end
			random_bytes.push_back(8'h00);
		end

		// The receiver stalls for a long stretch while bytes keep coming.
		hold_asks++;
		while (random_bytes.size() != 0)
			send_byte(random_bytes.pop_front(), 0, NONE, NONE);
		byte_ch.valid <= 1'b0;

		while (expected_units.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/u8u16_pkg.sv
rtl/core/u8u16_in_if.sv
rtl/core/u8u16_out_if.sv
rtl/core/u8u16_decode.sv
rtl/core/u8u16_outq.sv
rtl/core/utf8_to_utf16_transcoder.sv
dv/tb_utf8_to_utf16_transcoder.sv
